// ===== rtl/nrt_pkg.sv =====
package nrt_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned DOM_ID_W  = 32;
  localparam int unsigned DOM_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_WRAP         = 3'd2,
    ST_DOMAINS_FULL = 3'd3,
    ST_RANGES_FULL  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LSUM,
    S_DSCAN,
    S_LCOMMIT,
    S_QUERY,
    S_RESP
  } state_e;

  // One stored range: inclusive start, exclusive end and the dense domain index.
  typedef struct packed {
    logic [ADDR_W-1:0]    ent_start;
    logic [ADDR_W-1:0]    ent_end;
    logic [DOM_IDX_W-1:0] dom;
  } range_ent_t;

  // Verdict of one stored range against a query.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] new_end;
  } ovl_t;

  typedef struct packed {
    status_e              status;
    logic [DOM_IDX_W-1:0] domain_index;
    logic [ADDR_W-1:0]    clip_start;
    logic [ADDR_W-1:0]    new_end;
  } result_t;

endpackage

// ===== rtl/nrt_if.sv =====
interface nrt_in_if import nrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [DOM_ID_W-1:0] domain_id;
  logic                range_enabled;
  logic [ADDR_W-1:0]   base_addr;
  logic [ADDR_W-1:0]   addr_len;
  logic [ADDR_W-1:0]   query_start;
  logic [ADDR_W-1:0]   query_end;

  modport source (
    output valid, opcode, domain_id, range_enabled, base_addr, addr_len,
           query_start, query_end,
    input  ready
  );
  modport sink (
    input  valid, opcode, domain_id, range_enabled, base_addr, addr_len,
           query_start, query_end,
    output ready
  );
endinterface

interface nrt_out_if import nrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [DOM_IDX_W-1:0] domain_index;
  logic [ADDR_W-1:0]    clip_start;
  logic [ADDR_W-1:0]    new_end;

  modport source (
    output valid, status, domain_index, clip_start, new_end,
    input  ready
  );
  modport sink (
    input  valid, status, domain_index, clip_start, new_end,
    output ready
  );
endinterface

// ===== rtl/nrt_overlap.sv =====
module nrt_overlap import nrt_pkg::*; (
  input  logic [ADDR_W-1:0] ent_start_i,
  input  logic [ADDR_W-1:0] ent_end_i,
  input  logic [ADDR_W-1:0] query_start_i,
  input  logic [ADDR_W-1:0] query_end_i,
  output ovl_t              ovl_o
);

  logic start_ge_rs;
  logic start_lt_re;
  logic end_le_re;
  logic end_ge_rs;

  assign start_ge_rs = query_start_i >= ent_start_i;
  assign start_lt_re = query_start_i < ent_end_i;
  assign end_le_re   = query_end_i <= ent_end_i;
  assign end_ge_rs   = query_end_i >= ent_start_i;

  // A query starting inside the range is clipped at the range end; one starting
  // below it is cut at the range start.
  always_comb begin
    if (start_ge_rs) begin
      ovl_o.hit     = start_lt_re;
      ovl_o.new_end = end_le_re ? query_end_i : ent_end_i;
    end else begin
      ovl_o.hit     = end_ge_rs;
      ovl_o.new_end = ent_start_i;
    end
  end

endmodule

// ===== rtl/numa_range_table_lookup.sv =====
// Memory-affinity range table. Loads append (start, end, domain) entries and
// map each 32-bit domain identifier to a dense index; queries return the first
// stored range that overlaps and the clipped range; a clear empties both tables.
// One item is handled at a time. A load first sums base and length and stops
// with a wraparound status if the sum wraps; it then scans the domain memory
// for its identifier, stopping at the first match or after the last stored
// domain, and commits the range, and the identifier when it is new, unless a
// table is full. A query scans the range memory up to the first overlapping
// range or the end of the table. A clear, an ignored load or an unknown opcode
// goes straight to the response step. Both scans read one entry per cycle
// through the single read port of their memory. The result sits in an output
// register, so the next item can be taken as soon as a result is presented,
// even while it waits; a further result then stalls until that register
// drains.
module numa_range_table_lookup import nrt_pkg::*; #(
  parameter int unsigned RANGE_ENTRIES  = 256,
  parameter int unsigned DOMAIN_ENTRIES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nrt_in_if.sink    in_i,
  nrt_out_if.source out_o
);

  localparam int unsigned RIDX_W = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int unsigned DIDX_W = (DOMAIN_ENTRIES > 1) ? $clog2(DOMAIN_ENTRIES) : 1;
  localparam int unsigned RCNT_W = $clog2(RANGE_ENTRIES + 1);
  localparam int unsigned DCNT_W = $clog2(DOMAIN_ENTRIES + 1);

  localparam logic [RCNT_W-1:0] RANGE_MAX  = RCNT_W'(RANGE_ENTRIES);
  localparam logic [DCNT_W-1:0] DOMAIN_MAX = DCNT_W'(DOMAIN_ENTRIES);

  typedef struct packed {
    logic [DOM_ID_W-1:0] dom;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   len;
    logic [ADDR_W-1:0]   qs;
    logic [ADDR_W-1:0]   qe;
  } req_t;

  state_e state_q, state_d;
  req_t   req_q;
  logic   in_fire;

  logic [ADDR_W-1:0] stop_q, stop_d;
  logic [ADDR_W-1:0] sum;
  logic              wrap;

  logic [RCNT_W-1:0] r_count_q, r_count_d;
  logic [DCNT_W-1:0] d_count_q, d_count_d;
  logic [RCNT_W-1:0] r_scan_q, r_scan_d;
  logic [DCNT_W-1:0] d_scan_q, d_scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [DIDX_W-1:0] d_rd_idx_q, d_rd_idx_d;
  logic              dom_hit_q, dom_hit_d;
  logic [DIDX_W-1:0] dom_idx_q, dom_idx_d;
  logic              r_issue;
  logic              d_issue;

  logic [DIDX_W-1:0]   new_idx;
  logic [DIDX_W+2:0]   idx_ext;

  result_t res_q, res_d;
  result_t out_q;
  logic    out_vld_q, out_vld_d;
  logic    out_load;

  // Range and domain memories, one read and one write port each.
  range_ent_t          r_mem [RANGE_ENTRIES];
  logic [DOM_ID_W-1:0] d_mem [DOMAIN_ENTRIES];
  range_ent_t          r_rdata_q;
  logic [DOM_ID_W-1:0] d_rdata_q;
  logic [RIDX_W-1:0]   r_raddr;
  logic [DIDX_W-1:0]   d_raddr;
  logic                r_we;
  logic                d_we;
  range_ent_t          r_wdata;

  ovl_t ovl;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign sum  = req_q.base + req_q.len;
  assign wrap = req_q.base > sum;

  assign r_issue = (state_q == S_QUERY) && (r_scan_q < r_count_q);
  assign d_issue = (state_q == S_DSCAN) && (d_scan_q < d_count_q);
  assign r_raddr = r_scan_q[RIDX_W-1:0];
  assign d_raddr = d_scan_q[DIDX_W-1:0];

  assign new_idx = dom_hit_q ? dom_idx_q : d_count_q[DIDX_W-1:0];
  assign idx_ext = {3'b000, new_idx};

  assign r_wdata.ent_start = req_q.base;
  assign r_wdata.ent_end   = stop_q;
  assign r_wdata.dom       = idx_ext[DOM_IDX_W-1:0];

  nrt_overlap u_overlap (
    .ent_start_i   (r_rdata_q.ent_start),
    .ent_end_i     (r_rdata_q.ent_end),
    .query_start_i (req_q.qs),
    .query_end_i   (req_q.qe),
    .ovl_o         (ovl)
  );

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      r_mem[r_count_q[RIDX_W-1:0]] <= r_wdata;
    end
    r_rdata_q <= r_mem[r_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      d_mem[d_count_q[DIDX_W-1:0]] <= req_q.dom;
    end
    d_rdata_q <= d_mem[d_raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (opcode_e'(in_i.opcode))
            OP_LOAD:  state_d = in_i.range_enabled ? S_LSUM : S_RESP;
            OP_QUERY: state_d = S_QUERY;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_LSUM: begin
        state_d = wrap ? S_RESP : S_DSCAN;
      end
      S_DSCAN: begin
        if ((rd_vld_q && (d_rdata_q == req_q.dom)) || (!rd_vld_q && !d_issue)) begin
          state_d = S_LCOMMIT;
        end
      end
      S_LCOMMIT: begin
        state_d = S_RESP;
      end
      S_QUERY: begin
        if ((rd_vld_q && ovl.hit) || (!rd_vld_q && !r_issue)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    stop_d     = stop_q;
    r_count_d  = r_count_q;
    d_count_d  = d_count_q;
    r_scan_d   = r_scan_q;
    d_scan_d   = d_scan_q;
    rd_vld_d   = 1'b0;
    d_rd_idx_d = d_rd_idx_q;
    dom_hit_d  = dom_hit_q;
    dom_idx_d  = dom_idx_q;
    res_d      = res_q;
    r_we       = 1'b0;
    d_we       = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_d     = '0;
          r_scan_d  = '0;
          d_scan_d  = '0;
          dom_hit_d = 1'b0;
          if (opcode_e'(in_i.opcode) == OP_CLEAR) begin
            r_count_d = '0;
            d_count_d = '0;
          end
        end
      end
      S_LSUM: begin
        stop_d = sum;
        if (wrap) begin
          res_d.status = ST_WRAP;
        end
      end
      S_DSCAN: begin
        rd_vld_d   = d_issue;
        d_rd_idx_d = d_scan_q[DIDX_W-1:0];
        if (d_issue) begin
          d_scan_d = d_scan_q + 1'b1;
        end
        if (rd_vld_q && (d_rdata_q == req_q.dom)) begin
          dom_hit_d = 1'b1;
          dom_idx_d = d_rd_idx_q;
          rd_vld_d  = 1'b0;
        end
      end
      S_LCOMMIT: begin
        if (!dom_hit_q && (d_count_q >= DOMAIN_MAX)) begin
          res_d.status = ST_DOMAINS_FULL;
        end else if (r_count_q >= RANGE_MAX) begin
          res_d.status = ST_RANGES_FULL;
        end else begin
          r_we      = 1'b1;
          r_count_d = r_count_q + 1'b1;
          if (!dom_hit_q) begin
            d_we      = 1'b1;
            d_count_d = d_count_q + 1'b1;
          end
        end
      end
      S_QUERY: begin
        rd_vld_d = r_issue;
        if (r_issue) begin
          r_scan_d = r_scan_q + 1'b1;
        end
        if (rd_vld_q && ovl.hit) begin
          rd_vld_d           = 1'b0;
          res_d.status       = ST_OK;
          res_d.domain_index = r_rdata_q.dom;
          res_d.clip_start   = req_q.qs;
          res_d.new_end      = ovl.new_end;
        end else if (!rd_vld_q && !r_issue) begin
          res_d.status = ST_NOT_FOUND;
        end
      end
      S_RESP: begin
        out_load = !out_vld_q || out_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      r_count_q <= '0;
      d_count_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      r_count_q <= r_count_d;
      d_count_q <= d_count_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.dom  <= in_i.domain_id;
      req_q.base <= in_i.base_addr;
      req_q.len  <= in_i.addr_len;
      req_q.qs   <= in_i.query_start;
      req_q.qe   <= in_i.query_end;
    end
    stop_q     <= stop_d;
    r_scan_q   <= r_scan_d;
    d_scan_q   <= d_scan_d;
    d_rd_idx_q <= d_rd_idx_d;
    dom_hit_q  <= dom_hit_d;
    dom_idx_q  <= dom_idx_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_q.status;
  assign out_o.domain_index = out_q.domain_index;
  assign out_o.clip_start   = out_q.clip_start;
  assign out_o.new_end      = out_q.new_end;

  a_range_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_count_q <= RANGE_MAX)
    else $error("range count beyond table depth");

  a_domain_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_count_q <= DOMAIN_MAX)
    else $error("domain count beyond table depth");

  a_range_write_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_we |-> (r_count_q < RANGE_MAX) && (state_q == S_LCOMMIT))
    else $error("range write without room");

  a_domain_write_new : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_we |-> r_we && !dom_hit_q && (d_count_q < DOMAIN_MAX))
    else $error("domain write for a known or unfit identifier");

  a_result_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_RESP))
    else $error("result presented outside the response step");

  a_no_read_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !rd_vld_q)
    else $error("transfer taken while a table read is in flight");

endmodule
